>>> hdl/vt52_pkg.sv
`default_nettype none

package vt52_pkg;

    // Result command codes
    localparam logic [3:0] CMD_PLOT        = 4'd0;
    localparam logic [3:0] CMD_CLEAR_ACROSS = 4'd1;
    localparam logic [3:0] CMD_CLEAR_LINES = 4'd2;
    localparam logic [3:0] CMD_SCROLL_UP   = 4'd3;
    localparam logic [3:0] CMD_SCROLL_DOWN = 4'd4;
    localparam logic [3:0] CMD_BEEP        = 4'd5;
    localparam logic [3:0] CMD_CURSOR_OFF  = 4'd6;
    localparam logic [3:0] CMD_ATTRIBUTES  = 4'd7;
    localparam logic [3:0] CMD_REPORT      = 4'd8;

    // Configuration register indexes
    localparam logic CFG_LAST_COLUMN = 1'b0;
    localparam logic CFG_LAST_ROW    = 1'b1;

    // Reset values
    localparam logic [6:0] LAST_COLUMN_RESET = 7'd79;
    localparam logic [5:0] LAST_ROW_RESET    = 6'd23;
    localparam logic [7:0] INK_RESET         = 8'd7;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DECODE,
        OP_PLOT,
        OP_SCROLL_UP,
        OP_CLEAR_BOTTOM,
        OP_SECOND,
        OP_REPORT
    } op_t;

    // Datapath status back to the controller
    typedef struct packed {
        logic free;      // output register can take a result this cycle
        logic plot;      // current operation plotted a character
        logic tab;       // decoded byte is a tab
        logic scroll;    // cursor settle runs off the bottom
        logic more;      // column after the plot is not on a tab stop
        logic second;    // decoded escape needs a second result
        logic col_open;  // current cursor column is not on a tab stop
    } status_t;

endpackage

`default_nettype wire

>>> hdl/vt52_ctrl.sv
`default_nettype none

module vt52_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire vt52_pkg::status_t status,
    output vt52_pkg::op_t          op
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PLOT,
        S_SCROLL_UP,
        S_CLEAR_BOTTOM,
        S_SECOND,
        S_REPORT
    } state_t;

    state_t state_reg;
    logic   tab_reg;
    logic   stall_reg;

    assign in_stall = stall_reg;

    // Operation for this cycle; result-producing steps wait for a free slot
    always_comb
    begin
        op = vt52_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    op = vt52_pkg::OP_LOAD;
            end
            S_DECODE:
            begin
                if (status.free)
                    op = vt52_pkg::OP_DECODE;
            end
            S_PLOT:
            begin
                if (status.free)
                    op = vt52_pkg::OP_PLOT;
            end
            S_SCROLL_UP:
            begin
                if (status.free)
                    op = vt52_pkg::OP_SCROLL_UP;
            end
            S_CLEAR_BOTTOM:
            begin
                if (status.free)
                    op = vt52_pkg::OP_CLEAR_BOTTOM;
            end
            S_SECOND:
            begin
                if (status.free)
                    op = vt52_pkg::OP_SECOND;
            end
            S_REPORT:
            begin
                if (status.free)
                    op = vt52_pkg::OP_REPORT;
            end
            default:
            begin
                op = vt52_pkg::OP_NONE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tab_reg   <= 1'b0;
            stall_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_DECODE;
                        stall_reg <= 1'b1;
                    end
                end
                S_DECODE:
                begin
                    if (status.free)
                    begin
                        tab_reg <= status.tab;
                        if (status.plot)
                        begin
                            if (status.scroll)
                                state_reg <= S_SCROLL_UP;
                            else if (status.tab && status.more)
                                state_reg <= S_PLOT;
                            else
                                state_reg <= S_REPORT;
                        end
                        else if (status.scroll)
                            state_reg <= S_CLEAR_BOTTOM;
                        else if (status.second)
                            state_reg <= S_SECOND;
                        else
                            state_reg <= S_REPORT;
                    end
                end
                S_PLOT:
                begin
                    if (status.free)
                    begin
                        if (status.scroll)
                            state_reg <= S_SCROLL_UP;
                        else if (status.more)
                            state_reg <= S_PLOT;
                        else
                            state_reg <= S_REPORT;
                    end
                end
                S_SCROLL_UP:
                begin
                    if (status.free)
                        state_reg <= S_CLEAR_BOTTOM;
                end
                S_CLEAR_BOTTOM:
                begin
                    if (status.free)
                    begin
                        if (tab_reg && status.col_open)
                            state_reg <= S_PLOT;
                        else
                            state_reg <= S_REPORT;
                    end
                end
                S_SECOND:
                begin
                    if (status.free)
                        state_reg <= S_REPORT;
                end
                S_REPORT:
                begin
                    if (status.free)
                    begin
                        state_reg <= S_IDLE;
                        stall_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    stall_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/vt52_dp.sv
`default_nettype none

module vt52_dp
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire vt52_pkg::op_t     op,
    output vt52_pkg::status_t      status,
    input  wire logic [7:0]        data,
    input  wire logic              cfg_write,
    input  wire logic              cfg_index,
    input  wire logic [6:0]        cfg_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [3:0]             command,
    output logic [5:0]             row,
    output logic [6:0]             column,
    output logic [7:0]             count,
    output logic [7:0]             value,
    output logic [7:0]             ink,
    output logic [7:0]             paper,
    output logic                   hidden,
    output logic                   last
);

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_ESC    = 3'd1,
        M_ROW    = 3'd2,
        M_COL    = 3'd3,
        M_ATTR   = 3'd4,
        M_INK    = 3'd5,
        M_PAPER  = 3'd6
    } mode_t;

    typedef struct packed {
        logic [3:0] command;
        logic [5:0] row;
        logic [6:0] column;
        logic [7:0] count;
        logic [7:0] value;
        logic [7:0] ink;
        logic [7:0] paper;
        logic       hidden;
        logic       last;
    } item_t;

    typedef struct packed {
        logic       scroll;
        logic [6:0] col;
        logic [5:0] row;
    } settle_t;

    // Byte codes
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UP    = 8'h41;  // A
    localparam logic [7:0] CH_DOWN  = 8'h42;  // B
    localparam logic [7:0] CH_RIGHT = 8'h43;  // C
    localparam logic [7:0] CH_LEFT  = 8'h44;  // D
    localparam logic [7:0] CH_ERASE = 8'h45;  // E
    localparam logic [7:0] CH_HOME  = 8'h48;  // H
    localparam logic [7:0] CH_RLF   = 8'h49;  // I
    localparam logic [7:0] CH_EOS   = 8'h4a;  // J
    localparam logic [7:0] CH_EOL   = 8'h4b;  // K
    localparam logic [7:0] CH_ADDR  = 8'h59;  // Y
    localparam logic [7:0] CH_ATTR  = 8'h61;  // a
    localparam logic [7:0] CH_INK   = 8'h62;  // b
    localparam logic [7:0] CH_PAPER = 8'h63;  // c
    localparam logic [7:0] CH_SHOW  = 8'h65;  // e
    localparam logic [7:0] CH_HIDE  = 8'h66;  // f

    // Cursor move with wrap back, wrap forward and scroll at the bottom
    function automatic settle_t settle(input logic signed [8:0] x_in,
                                       input logic signed [7:0] y_in,
                                       input logic [6:0] right,
                                       input logic [5:0] bottom);
        logic signed [8:0] x;
        logic signed [7:0] y;
        settle_t           r;
        x = x_in;
        y = y_in;
        r.scroll = 1'b0;
        if (x < 9'sd0)
        begin
            x = $signed({2'b00, right});
            y = y - 8'sd1;
        end
        if (y < 8'sd0)
            y = 8'sd0;
        if (x > $signed({2'b00, right}))
        begin
            x = 9'sd0;
            y = y + 8'sd1;
        end
        if (y > $signed({2'b00, bottom}))
        begin
            r.scroll = 1'b1;
            y = $signed({2'b00, bottom});
        end
        r.col = x[6:0];
        r.row = y[5:0];
        return r;
    endfunction

    logic [6:0] lcol_reg;
    logic [5:0] lrow_reg;
    mode_t      mode_reg, mode_next;
    logic [5:0] row_reg, row_next;
    logic [6:0] col_reg, col_next;
    logic [7:0] prow_reg, prow_next;
    logic       hid_reg, hid_next;
    logic [7:0] attr_reg, attr_next;
    logic [7:0] ink_reg, ink_next;
    logic [7:0] paper_reg, paper_next;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    item_t      item_reg, item_next;
    logic       emit;

    logic signed [8:0] across;
    logic [7:0]        across_cnt;
    logic [7:0]        lines_cnt;
    logic [7:0]        addr_col;
    settle_t           s_plot;
    settle_t           s_back;
    settle_t           s_feed;
    logic              free;

    assign free = !out_valid_reg || !out_stall;

    // Settle candidates for plot advance, backspace and line feed
    assign s_plot = settle($signed({2'b00, col_reg}) + 9'sd1, $signed({2'b00, row_reg}),
                           lcol_reg, lrow_reg);
    assign s_back = settle($signed({2'b00, col_reg}) - 9'sd1, $signed({2'b00, row_reg}),
                           lcol_reg, lrow_reg);
    assign s_feed = settle($signed({2'b00, col_reg}), $signed({2'b00, row_reg}) + 8'sd1,
                           lcol_reg, lrow_reg);

    // Clear counts
    assign across     = $signed({2'b00, lcol_reg}) - $signed({2'b00, col_reg}) + 9'sd1;
    assign across_cnt = (across < 9'sd0) ? 8'd0 : across[7:0];
    assign lines_cnt  = (row_reg < lrow_reg) ? {2'b00, lrow_reg - row_reg} : 8'd0;
    assign addr_col   = byte_reg - CH_SPACE;

    // Operation decode and next state
    always_comb
    begin
        mode_next  = mode_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        prow_next  = prow_reg;
        hid_next   = hid_reg;
        attr_next  = attr_reg;
        ink_next   = ink_reg;
        paper_next = paper_reg;
        emit       = 1'b0;
        item_next  = '0;
        status     = '0;
        status.free     = free;
        status.more     = (s_plot.col[2:0] != 3'd0);
        status.col_open = (col_reg[2:0] != 3'd0);

        case (op)
            vt52_pkg::OP_DECODE:
            begin
                case (mode_reg)
                    M_ESC:
                    begin
                        mode_next = M_NORMAL;
                        case (byte_reg)
                            CH_UP:
                            begin
                                if (row_reg != 6'd0)
                                    row_next = row_reg - 6'd1;
                            end
                            CH_DOWN:
                            begin
                                if (row_reg < lrow_reg)
                                    row_next = row_reg + 6'd1;
                            end
                            CH_RIGHT:
                            begin
                                if (col_reg < lcol_reg)
                                    col_next = col_reg + 7'd1;
                            end
                            CH_LEFT:
                            begin
                                if (col_reg != 7'd0)
                                    col_next = col_reg - 7'd1;
                            end
                            CH_ERASE:
                            begin
                                emit              = 1'b1;
                                item_next.command = vt52_pkg::CMD_CLEAR_LINES;
                                item_next.count   = {2'b00, lrow_reg} + 8'd1;
                            end
                            CH_HOME:
                            begin
                                row_next = 6'd0;
                                col_next = 7'd0;
                            end
                            CH_RLF:
                            begin
                                if (row_reg != 6'd0)
                                    row_next = row_reg - 6'd1;
                                else
                                begin
                                    emit              = 1'b1;
                                    item_next.command = vt52_pkg::CMD_SCROLL_DOWN;
                                    status.second     = 1'b1;
                                end
                            end
                            CH_EOS, CH_EOL:
                            begin
                                emit              = 1'b1;
                                item_next.command = vt52_pkg::CMD_CLEAR_ACROSS;
                                item_next.row     = row_reg;
                                item_next.column  = col_reg;
                                item_next.count   = across_cnt;
                                status.second     = (byte_reg == CH_EOS);
                            end
                            CH_SHOW:
                            begin
                                hid_next = 1'b0;
                            end
                            CH_HIDE:
                            begin
                                hid_next          = 1'b1;
                                emit              = 1'b1;
                                item_next.command = vt52_pkg::CMD_CURSOR_OFF;
                            end
                            CH_ADDR:  mode_next = M_ROW;
                            CH_ATTR:  mode_next = M_ATTR;
                            CH_INK:   mode_next = M_INK;
                            CH_PAPER: mode_next = M_PAPER;
                            default:
                            begin
                                mode_next = M_NORMAL;
                            end
                        endcase
                    end
                    M_ROW:
                    begin
                        prow_next = byte_reg - CH_SPACE;
                        mode_next = M_COL;
                    end
                    M_COL:
                    begin
                        if (prow_reg <= {2'b00, lrow_reg})
                            row_next = prow_reg[5:0];
                        if ((byte_reg >= CH_SPACE) && (addr_col <= {1'b0, lcol_reg}))
                            col_next = addr_col[6:0];
                        mode_next = M_NORMAL;
                    end
                    M_ATTR, M_INK, M_PAPER:
                    begin
                        mode_next         = M_NORMAL;
                        emit              = 1'b1;
                        item_next.command = vt52_pkg::CMD_ATTRIBUTES;
                        item_next.value   = attr_reg;
                        item_next.ink     = ink_reg;
                        item_next.paper   = paper_reg;
                        if (mode_reg == M_ATTR)
                        begin
                            attr_next       = byte_reg;
                            item_next.value = byte_reg;
                        end
                        else if (mode_reg == M_INK)
                        begin
                            ink_next      = byte_reg;
                            item_next.ink = byte_reg;
                        end
                        else
                        begin
                            paper_next      = byte_reg;
                            item_next.paper = byte_reg;
                        end
                    end
                    default:
                    begin
                        // Normal mode, and the unreachable mode seven
                        mode_next = M_NORMAL;
                        case (byte_reg)
                            CH_BEL:
                            begin
                                emit              = 1'b1;
                                item_next.command = vt52_pkg::CMD_BEEP;
                            end
                            CH_BS:
                            begin
                                row_next          = s_back.row;
                                col_next          = s_back.col;
                                status.scroll     = s_back.scroll;
                                emit              = s_back.scroll;
                                item_next.command = vt52_pkg::CMD_SCROLL_UP;
                            end
                            CH_LF:
                            begin
                                row_next          = s_feed.row;
                                col_next          = s_feed.col;
                                status.scroll     = s_feed.scroll;
                                emit              = s_feed.scroll;
                                item_next.command = vt52_pkg::CMD_SCROLL_UP;
                            end
                            CH_CR:
                            begin
                                col_next = 7'd0;
                            end
                            CH_ESC:
                            begin
                                mode_next = M_ESC;
                            end
                            default:
                            begin
                                // Plot, a tab starts with a space
                                emit              = 1'b1;
                                item_next.command = vt52_pkg::CMD_PLOT;
                                item_next.row     = row_reg;
                                item_next.column  = col_reg;
                                item_next.value   = (byte_reg == CH_TAB) ? CH_SPACE : byte_reg;
                                row_next          = s_plot.row;
                                col_next          = s_plot.col;
                                status.plot       = 1'b1;
                                status.tab        = (byte_reg == CH_TAB);
                                status.scroll     = s_plot.scroll;
                            end
                        endcase
                    end
                endcase
            end
            vt52_pkg::OP_PLOT:
            begin
                // Tab padding space
                emit              = 1'b1;
                item_next.command = vt52_pkg::CMD_PLOT;
                item_next.row     = row_reg;
                item_next.column  = col_reg;
                item_next.value   = CH_SPACE;
                row_next          = s_plot.row;
                col_next          = s_plot.col;
                status.plot       = 1'b1;
                status.tab        = 1'b1;
                status.scroll     = s_plot.scroll;
            end
            vt52_pkg::OP_SCROLL_UP:
            begin
                emit              = 1'b1;
                item_next.command = vt52_pkg::CMD_SCROLL_UP;
            end
            vt52_pkg::OP_CLEAR_BOTTOM:
            begin
                emit              = 1'b1;
                item_next.command = vt52_pkg::CMD_CLEAR_LINES;
                item_next.row     = lrow_reg;
                item_next.count   = 8'd1;
            end
            vt52_pkg::OP_SECOND:
            begin
                // Clear after reverse line feed, or below the cursor
                emit              = 1'b1;
                item_next.command = vt52_pkg::CMD_CLEAR_LINES;
                if (byte_reg == CH_RLF)
                    item_next.count = 8'd1;
                else
                begin
                    item_next.row   = row_reg + 6'd1;
                    item_next.count = lines_cnt;
                end
            end
            vt52_pkg::OP_REPORT:
            begin
                emit              = 1'b1;
                item_next.command = vt52_pkg::CMD_REPORT;
                item_next.row     = row_reg;
                item_next.column  = col_reg;
                item_next.hidden  = hid_reg;
                item_next.last    = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Terminal state and limits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcol_reg  <= vt52_pkg::LAST_COLUMN_RESET;
            lrow_reg  <= vt52_pkg::LAST_ROW_RESET;
            mode_reg  <= M_NORMAL;
            row_reg   <= 6'd0;
            col_reg   <= 7'd0;
            prow_reg  <= 8'd0;
            hid_reg   <= 1'b0;
            attr_reg  <= 8'd0;
            ink_reg   <= vt52_pkg::INK_RESET;
            paper_reg <= 8'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == vt52_pkg::CFG_LAST_COLUMN)
                    lcol_reg <= cfg_data;
                else
                    lrow_reg <= cfg_data[5:0];
            end
            mode_reg  <= mode_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            prow_reg  <= prow_next;
            hid_reg   <= hid_next;
            attr_reg  <= attr_next;
            ink_reg   <= ink_next;
            paper_reg <= paper_next;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Input byte and output payload
    always_ff @(posedge clk)
    begin
        if (op == vt52_pkg::OP_LOAD)
            byte_reg <= data;
        if (emit)
            item_reg <= item_next;
    end

    assign out_valid = out_valid_reg;
    assign command   = item_reg.command;
    assign row       = item_reg.row;
    assign column    = item_reg.column;
    assign count     = item_reg.count;
    assign value     = item_reg.value;
    assign ink       = item_reg.ink;
    assign paper     = item_reg.paper;
    assign hidden    = item_reg.hidden;
    assign last      = item_reg.last;

endmodule

`default_nettype wire

>>> hdl/vt52_escape_interpreter.sv
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid / in_stall     data
// output    out_valid / out_stall   command row column count value ink paper hidden last
// config    cfg_write               cfg_index cfg_data
//
// One byte at a time: the controller takes the byte, decodes it (its first result,
// if any), then steps out each further result, the cursor report last; the controller
// steps the output register one result per cycle while out_stall is low.
// Reset (rst_n, asynchronous) restores the limits 79/23, home cursor, ink 7.
// out_stall holds the current result; in_stall is high until the report is loaded.

module vt52_escape_interpreter
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [3:0]      command,
    output logic [5:0]      row,
    output logic [6:0]      column,
    output logic [7:0]      count,
    output logic [7:0]      value,
    output logic [7:0]      ink,
    output logic [7:0]      paper,
    output logic            hidden,
    output logic            last,
    input  wire logic       cfg_write,
    input  wire logic       cfg_index,
    input  wire logic [6:0] cfg_data
);

    vt52_pkg::op_t     op;
    vt52_pkg::status_t status;

    // Sequencer
    vt52_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .op       (op)
    );

    // Terminal state and result datapath
    vt52_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .status    (status),
        .data      (data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .command   (command),
        .row       (row),
        .column    (column),
        .count     (count),
        .value     (value),
        .ink       (ink),
        .paper     (paper),
        .hidden    (hidden),
        .last      (last)
    );

endmodule

`default_nettype wire

>>> tb/sv/vt52_command_checker.sv
`timescale 1ns / 100ps

// Byte codes seen on the terminal stream, shared by stimulus and checker
package vt52_bytes_pkg;

    localparam logic [7:0] ASCII_BEL   = 8'h07;
    localparam logic [7:0] ASCII_BS    = 8'h08;
    localparam logic [7:0] ASCII_TAB   = 8'h09;
    localparam logic [7:0] ASCII_LF    = 8'h0a;
    localparam logic [7:0] ASCII_CR    = 8'h0d;
    localparam logic [7:0] ASCII_ESC   = 8'h1b;
    localparam logic [7:0] ASCII_SPACE = 8'h20;

    // Direct cursor addressing bias
    localparam logic [7:0] COORD_BIAS  = 8'h20;

    // Keys that follow ESC
    localparam logic [7:0] KEY_UP           = "A";
    localparam logic [7:0] KEY_DOWN         = "B";
    localparam logic [7:0] KEY_RIGHT        = "C";
    localparam logic [7:0] KEY_LEFT         = "D";
    localparam logic [7:0] KEY_ERASE_SCREEN = "E";
    localparam logic [7:0] KEY_HOME         = "H";
    localparam logic [7:0] KEY_REVERSE_LF   = "I";
    localparam logic [7:0] KEY_ERASE_EOS    = "J";
    localparam logic [7:0] KEY_ERASE_EOL    = "K";
    localparam logic [7:0] KEY_CURSOR_ON    = "e";
    localparam logic [7:0] KEY_CURSOR_OFF   = "f";
    localparam logic [7:0] KEY_ADDRESS      = "Y";
    localparam logic [7:0] KEY_ATTR         = "a";
    localparam logic [7:0] KEY_INK          = "b";
    localparam logic [7:0] KEY_PAPER        = "c";

endpackage

module vt52_command_checker
    import vt52_pkg::*;
    import vt52_bytes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [3:0] command,
    input  logic [5:0] row,
    input  logic [6:0] column,
    input  logic [7:0] count,
    input  logic [7:0] value,
    input  logic [7:0] ink,
    input  logic [7:0] paper,
    input  logic       hidden,
    input  logic       last,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data,
    output int         mismatches,
    output int         outstanding,
    output int         bytes_seen,
    output int         cmds_seen
);

    typedef enum logic [2:0] {
        MODE_NORMAL    = 3'd0,
        MODE_AFTER_ESC = 3'd1,
        MODE_ROW       = 3'd2,
        MODE_COLUMN    = 3'd3,
        MODE_ATTR      = 3'd4,
        MODE_INK       = 3'd5,
        MODE_PAPER     = 3'd6
    } esc_mode_t;

    typedef struct packed {
        logic [3:0] cmd;
        logic [5:0] row;
        logic [6:0] col;
        logic [7:0] cnt;
        logic [7:0] val;
        logic [7:0] ink;
        logic [7:0] paper;
        logic       hid;
        logic       lst;
    } display_cmd_t;

    // Commands predicted but not yet seen on the output
    display_cmd_t pending_cmds [$];

    // Terminal state mirror
    esc_mode_t  mode;
    logic [5:0] cur_row;
    logic [6:0] cur_col;
    logic [7:0] held_row;
    logic       hide_flag;
    logic [7:0] attr_bits;
    logic [7:0] ink_byte;
    logic [7:0] paper_byte;
    logic [6:0] right_edge;
    logic [5:0] bottom_edge;

    int error_total = 0;
    int byte_total  = 0;
    int cmd_total   = 0;

    function automatic void push_cmd(logic [3:0] cmd, int r, int c, int n, logic [7:0] v,
                                     logic [7:0] i, logic [7:0] p, logic h, logic l);
        display_cmd_t e;
        e.cmd   = cmd;
        e.row   = r[5:0];
        e.col   = c[6:0];
        e.cnt   = n[7:0];
        e.val   = v;
        e.ink   = i;
        e.paper = p;
        e.hid   = h;
        e.lst   = l;
        pending_cmds.push_back(e);
    endfunction

    // Wrap at either edge, scroll once when running off the bottom
    function automatic void move_cursor(int x, int y);
        int right;
        int bottom;
        right  = int'(right_edge);
        bottom = int'(bottom_edge);
        if (x < 0)
        begin
            x = right;
            y--;
        end
        if (y < 0)
            y = 0;
        if (x > right)
        begin
            x = 0;
            y++;
        end
        if (y > bottom)
        begin
            push_cmd(CMD_SCROLL_UP, 0, 0, 0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
            push_cmd(CMD_CLEAR_LINES, bottom, 0, 1, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
            y = bottom;
        end
        cur_col = x[6:0];
        cur_row = y[5:0];
    endfunction

    function automatic void put_glyph(logic [7:0] c);
        push_cmd(CMD_PLOT, cur_row, cur_col, 0, c, 8'd0, 8'd0, 1'b0, 1'b0);
        move_cursor(int'(cur_col) + 1, int'(cur_row));
    endfunction

    // Cells from the cursor to the right edge; none when past it
    function automatic int cells_to_eol();
        int n;
        n = int'(right_edge) - int'(cur_col) + 1;
        return (n < 0) ? 0 : n;
    endfunction

    function automatic void push_attributes();
        push_cmd(CMD_ATTRIBUTES, 0, 0, 0, attr_bits, ink_byte, paper_byte, 1'b0, 1'b0);
    endfunction

    function automatic void plain_byte(logic [7:0] c);
        case (c)
            ASCII_BEL: push_cmd(CMD_BEEP, 0, 0, 0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
            ASCII_BS:  move_cursor(int'(cur_col) - 1, int'(cur_row));
            ASCII_TAB:
            begin
                do
                    put_glyph(ASCII_SPACE);
                while (cur_col[2:0] != 3'd0);
                move_cursor(int'(cur_col), int'(cur_row));
            end
            ASCII_LF:  move_cursor(int'(cur_col), int'(cur_row) + 1);
            ASCII_CR:  cur_col = 7'd0;
            ASCII_ESC: mode = MODE_AFTER_ESC;
            default:   put_glyph(c);
        endcase
    endfunction

    // Key after ESC; returns the mode that follows
    function automatic esc_mode_t escape_key(logic [7:0] c);
        int lines;
        case (c)
            KEY_UP:
                if (cur_row != 6'd0)
                    cur_row = cur_row - 6'd1;
            KEY_DOWN:
                if (cur_row < bottom_edge)
                    cur_row = cur_row + 6'd1;
            KEY_RIGHT:
                if (cur_col < right_edge)
                    cur_col = cur_col + 7'd1;
            KEY_LEFT:
                if (cur_col != 7'd0)
                    cur_col = cur_col - 7'd1;
            KEY_ERASE_SCREEN:
                push_cmd(CMD_CLEAR_LINES, 0, 0, int'(bottom_edge) + 1,
                         8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
            KEY_HOME:
            begin
                cur_col = 7'd0;
                cur_row = 6'd0;
            end
            KEY_REVERSE_LF:
                if (cur_row != 6'd0)
                    cur_row = cur_row - 6'd1;
                else
                begin
                    push_cmd(CMD_SCROLL_DOWN, 0, 0, 0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
                    push_cmd(CMD_CLEAR_LINES, 0, 0, 1, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
                end
            KEY_ERASE_EOS:
            begin
                lines = (cur_row < bottom_edge) ? int'(bottom_edge) - int'(cur_row) : 0;
                push_cmd(CMD_CLEAR_ACROSS, cur_row, cur_col, cells_to_eol(),
                         8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
                push_cmd(CMD_CLEAR_LINES, int'(cur_row) + 1, 0, lines,
                         8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
            end
            KEY_ERASE_EOL:
                push_cmd(CMD_CLEAR_ACROSS, cur_row, cur_col, cells_to_eol(),
                         8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
            KEY_CURSOR_ON:
                hide_flag = 1'b0;
            KEY_CURSOR_OFF:
            begin
                hide_flag = 1'b1;
                push_cmd(CMD_CURSOR_OFF, 0, 0, 0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
            end
            KEY_ADDRESS: return MODE_ROW;
            KEY_ATTR:    return MODE_ATTR;
            KEY_INK:     return MODE_INK;
            KEY_PAPER:   return MODE_PAPER;
            default: ;
        endcase
        return MODE_NORMAL;
    endfunction

    // Predict every command caused by one byte, cursor report last
    function automatic void interpret_byte(logic [7:0] c);
        int col;
        col = int'(c) - int'(COORD_BIAS);
        case (mode)
            MODE_AFTER_ESC: mode = escape_key(c);
            MODE_ROW:
            begin
                held_row = c - COORD_BIAS;
                mode = MODE_COLUMN;
            end
            MODE_COLUMN:
            begin
                if (held_row <= {2'b00, bottom_edge})
                    cur_row = held_row[5:0];
                if (col >= 0 && col <= int'(right_edge))
                    cur_col = col[6:0];
                mode = MODE_NORMAL;
            end
            MODE_ATTR:
            begin
                attr_bits = c;
                mode = MODE_NORMAL;
                push_attributes();
            end
            MODE_INK:
            begin
                ink_byte = c;
                mode = MODE_NORMAL;
                push_attributes();
            end
            MODE_PAPER:
            begin
                paper_byte = c;
                mode = MODE_NORMAL;
                push_attributes();
            end
            // normal mode, and the unreachable eighth mode
            default:
            begin
                mode = MODE_NORMAL;
                plain_byte(c);
            end
        endcase
        push_cmd(CMD_REPORT, cur_row, cur_col, 0, 8'd0, 8'd0, 8'd0, hide_flag, 1'b1);
    endfunction

    function automatic int field_errors(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    // Watch all three ports; compare outputs before predicting new input
    always @(posedge clk or negedge rst_n)
    begin : watch
        display_cmd_t want;
        int bad;
        if (!rst_n)
        begin
            mode        = MODE_NORMAL;
            cur_row     = 6'd0;
            cur_col     = 7'd0;
            held_row    = 8'd0;
            hide_flag   = 1'b0;
            attr_bits   = 8'd0;
            ink_byte    = INK_RESET;
            paper_byte  = 8'd0;
            right_edge  = LAST_COLUMN_RESET;
            bottom_edge = LAST_ROW_RESET;
            pending_cmds.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                cmd_total++;
                if (pending_cmds.size() == 0)
                begin
                    $display("%0t ns: command %0d (row %0d col %0d) with none expected",
                             $time, command, row, column);
                    error_total++;
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    bad = field_errors("command", want.cmd, command)
                        + field_errors("row", want.row, row)
                        + field_errors("column", want.col, column)
                        + field_errors("count", want.cnt, count)
                        + field_errors("value", want.val, value)
                        + field_errors("ink", want.ink, ink)
                        + field_errors("paper", want.paper, paper)
                        + field_errors("hidden", want.hid, hidden)
                        + field_errors("last", want.lst, last);
                    if (bad != 0)
                        error_total++;
                end
            end

            if (cfg_write)
            begin
                if (cfg_index == CFG_LAST_COLUMN)
                    right_edge = cfg_data;
                else
                    bottom_edge = cfg_data[5:0];
            end

            if (in_valid && !in_stall)
            begin
                byte_total++;
                interpret_byte(data);
            end
        end
        mismatches  <= error_total;
        outstanding <= pending_cmds.size();
        bytes_seen  <= byte_total;
        cmds_seen   <= cmd_total;
    end

endmodule

>>> tb/sv/tb_vt52_escape_interpreter.sv
`timescale 1ns / 100ps

module tb_vt52_escape_interpreter;
    import vt52_pkg::*;
    import vt52_bytes_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int TIMEOUT_CYCLES  = 800000;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int BYTES_PER_PHASE = 12;
    localparam int NUM_PHASES      = 8;
    localparam int SETTLE_CYCLES   = 20;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] data      = 8'd0;
    logic       out_stall = 1'b0;
    logic       cfg_write = 1'b0;
    logic       cfg_index = 1'b0;
    logic [6:0] cfg_data  = 7'd0;

    logic       in_stall;
    logic       out_valid;
    logic [3:0] command;
    logic [5:0] row;
    logic [6:0] column;
    logic [7:0] count;
    logic [7:0] value;
    logic [7:0] ink;
    logic [7:0] paper;
    logic       hidden;
    logic       last;

    int mismatches;
    int outstanding;
    int bytes_seen;
    int cmds_seen;

    // Current limits, used to aim cursor addresses
    int right_limit  = 79;
    int bottom_limit = 23;
    int bytes_sent   = 0;
    bit hold_off_request = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    vt52_escape_interpreter dut (.*);

    vt52_command_checker chk (.*);

    // Watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timeout: output never drained");
        $display("Mismatches found");
        $finish;
    end

    // Output side: free runs, short stalls, occasional long stalls, one forced hold-off
    initial
    begin : receiver
        int pick;
        int span;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                pick = $urandom_range(0, 19);
                if (pick < 8)
                begin
                    out_stall <= 1'b0;
                    span = $urandom_range(1, 40);
                end
                else if (pick < 18)
                begin
                    out_stall <= 1'($urandom_range(0, 1));
                    span = $urandom_range(1, 3);
                end
                else
                begin
                    out_stall <= 1'b1;
                    span = $urandom_range(10, 60);
                end
                repeat (span - 1) @(posedge clk);
            end
        end
    end

    // Offer one byte after a random gap; returns at the accepting edge with valid still high
    task automatic send_byte(input logic [7:0] b);
        int pick;
        int gap;
        pick = $urandom_range(0, 19);
        if (pick < 10)
            gap = 0;
        else if (pick < 18)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    // Stop sending and wait for every predicted command
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limits(input int col, input int rw);
        cfg_write <= 1'b1;
        cfg_index <= CFG_LAST_COLUMN;
        cfg_data  <= col[6:0];
        @(posedge clk);
        cfg_index <= CFG_LAST_ROW;
        cfg_data  <= {1'b0, rw[5:0]};
        @(posedge clk);
        cfg_write <= 1'b0;
        right_limit  = col;
        bottom_limit = rw;
    endtask

    function automatic logic [7:0] control_code(int k);
        case (k)
            0:       return ASCII_BEL;
            1:       return ASCII_BS;
            2:       return ASCII_TAB;
            3:       return ASCII_LF;
            default: return ASCII_CR;
        endcase
    endfunction

    function automatic logic [7:0] escape_key_code(int k);
        case (k)
            0:       return KEY_UP;
            1:       return KEY_DOWN;
            2:       return KEY_RIGHT;
            3:       return KEY_LEFT;
            4:       return KEY_ERASE_SCREEN;
            5:       return KEY_HOME;
            6:       return KEY_REVERSE_LF;
            7:       return KEY_ERASE_EOS;
            8:       return KEY_ERASE_EOL;
            9:       return KEY_CURSOR_ON;
            default: return KEY_CURSOR_OFF;
        endcase
    endfunction

    // Address byte: mostly on screen, sometimes just past the limit, sometimes anything
    function automatic logic [7:0] coordinate(int limit);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return COORD_BIAS + 8'($urandom_range(0, limit));
        if (pick < 8)
            return COORD_BIAS + 8'(limit + 1);
        return 8'($urandom);
    endfunction

    // One random sequence: mostly well formed, some noise and broken escapes
    task automatic send_random_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            send_byte(8'($urandom_range(32, 126)));
        else if (pick < 45)
            send_byte(control_code($urandom_range(0, 4)));
        else if (pick < 65)
        begin
            send_byte(ASCII_ESC);
            send_byte(escape_key_code($urandom_range(0, 10)));
        end
        else if (pick < 75)
        begin
            send_byte(ASCII_ESC);
            send_byte(KEY_ADDRESS);
            send_byte(coordinate(bottom_limit));
            send_byte(coordinate(right_limit));
        end
        else if (pick < 82)
        begin
            send_byte(ASCII_ESC);
            case ($urandom_range(0, 2))
                0:       send_byte(KEY_ATTR);
                1:       send_byte(KEY_INK);
                default: send_byte(KEY_PAPER);
            endcase
            send_byte(8'($urandom));
        end
        else if (pick < 92)
            send_byte(8'($urandom));
        else
        begin
            send_byte(ASCII_ESC);
            send_byte(8'($urandom));
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int target;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening under the reset limits
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(ASCII_BEL);
        send_byte(ASCII_TAB);
        send_byte(ASCII_CR);
        send_byte(ASCII_LF);
        // backspace from home lands on the last column of row 0
        send_byte(ASCII_ESC);
        send_byte(KEY_HOME);
        send_byte(ASCII_BS);
        send_byte(ASCII_ESC);
        send_byte(KEY_CURSOR_OFF);
        // both address bytes off screen: cursor stays put
        send_byte(ASCII_ESC);
        send_byte(KEY_ADDRESS);
        send_byte(8'h1f);
        send_byte(8'hff);
        // reverse line feed on the top row scrolls down
        send_byte(ASCII_ESC);
        send_byte(KEY_REVERSE_LF);
        send_byte(ASCII_ESC);
        send_byte(KEY_ERASE_EOS);
        // second ESC is dropped
        send_byte(ASCII_ESC);
        send_byte(ASCII_ESC);
        send_byte(ASCII_ESC);
        send_byte(KEY_ATTR);
        send_byte(8'haa);
        wait_idle();

        // Random traffic, one phase per limit setting
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:       ;
                1:       write_limits(0, 0);
                2:       write_limits(127, 63);
                3:       write_limits(7, 2);
                4:       write_limits(127, 0);
                5:       write_limits(0, 63);
                6:       write_limits(15, 5);
                default: write_limits($urandom_range(0, 127), $urandom_range(0, 63));
            endcase
            // long output hold-off while input keeps coming
            if (phase == 3)
                hold_off_request = 1'b1;
            target = bytes_sent + BYTES_PER_PHASE;
            while (bytes_sent < target)
                send_random_sequence();
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d bytes across %0d limit settings, %0d display commands checked.",
                 bytes_seen, NUM_PHASES, cmds_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> vt52_escape_interpreter.f
hdl/vt52_pkg.sv
hdl/vt52_ctrl.sv
hdl/vt52_dp.sv
hdl/vt52_escape_interpreter.sv
tb/sv/vt52_command_checker.sv
tb/sv/tb_vt52_escape_interpreter.sv
